/* sv/rbft_pkg.sv */
`default_nettype none
package rbft_pkg;

   // Slot space and bitmap geometry
   localparam int unsigned MAX_SLOTS  = 1024;
   localparam int unsigned SLOT_W     = $clog2(MAX_SLOTS);
   localparam int unsigned COUNT_W    = SLOT_W + 1;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BIT_W      = $clog2(WORD_W);
   localparam int unsigned ROWS       = MAX_SLOTS / WORD_W;
   localparam int unsigned ROW_W      = SLOT_W - BIT_W;
   localparam int unsigned SCAN_W     = BIT_W + 1;

   // Field widths
   localparam int unsigned OFFSET_W   = 32;
   localparam int unsigned SIZE_W     = 14;
   localparam int unsigned TOTAL_W    = 11;

   // Division by the segment size through a rounded-up reciprocal.
   // Offsets below OFFSET_LIMIT fit NUM_W bits and divide exactly.
   localparam int unsigned SEGMENT_BYTES = 14324;
   localparam longint unsigned OFFSET_LIMIT = longint'(MAX_SLOTS) * SEGMENT_BYTES;
   localparam int unsigned NUM_W       = $clog2(OFFSET_LIMIT);
   localparam int unsigned RECIP_SHIFT = 38;
   localparam longint unsigned RECIP_MULT =
      ((longint'(1) << RECIP_SHIFT) + SEGMENT_BYTES - 1) / SEGMENT_BYTES;
   localparam int unsigned RECIP_W     = $clog2(RECIP_MULT + 1);
   localparam int unsigned PROD_W      = NUM_W + RECIP_W;

   // Queue between the front and back parts
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

   // One classified segment, handed from front to back
   typedef struct packed {
      logic [OFFSET_W-1:0] ack;
      logic [SLOT_W-1:0]   quot;
      logic                over;   // offset lies past the last possible slot
   } item_type;

endpackage
`default_nettype wire

/* sv/rbft_front.sv */
`default_nettype none
module rbft_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rbft_pkg::OFFSET_W-1:0] byte_offset,
   input  wire logic [rbft_pkg::SIZE_W-1:0]   payload_size,
   output logic                               push,
   output rbft_pkg::item_type                 push_item,
   input  wire logic                          fifo_full
);

   logic                             stage_valid_ff, stage_valid_in;
   logic [rbft_pkg::PROD_W-1:0]      prod_ff;
   logic [rbft_pkg::OFFSET_W-1:0]    ack_ff;
   logic                             over_ff;
   logic                             accept;

   assign busy   = stage_valid_ff & fifo_full;
   assign accept = start & ~busy;
   assign push   = stage_valid_ff & ~fifo_full;

   assign stage_valid_in = accept | (stage_valid_ff & ~push);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Multiply by the reciprocal; exact for any offset below the limit.
   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= rbft_pkg::PROD_W'(byte_offset[rbft_pkg::NUM_W-1:0])
                  * rbft_pkg::PROD_W'(rbft_pkg::RECIP_MULT);
         ack_ff  <= byte_offset + rbft_pkg::OFFSET_W'(payload_size);
         over_ff <= byte_offset >= rbft_pkg::OFFSET_W'(rbft_pkg::OFFSET_LIMIT);
      end
   end

   assign push_item.ack  = ack_ff;
   assign push_item.quot = prod_ff[rbft_pkg::RECIP_SHIFT +: rbft_pkg::SLOT_W];
   assign push_item.over = over_ff;

endmodule
`default_nettype wire

/* sv/rbft_fifo.sv */
`default_nettype none
module rbft_fifo (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rbft_pkg::item_type push_item,
   output logic              full,
   input  wire logic         pop,
   output rbft_pkg::item_type pop_item,
   output logic              empty
);

   rbft_pkg::item_type                  entry_ff [rbft_pkg::FIFO_DEPTH];
   logic [rbft_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [rbft_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [rbft_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                                do_push, do_pop;

   assign full     = count_ff == rbft_pkg::FIFO_CNT_W'(rbft_pkg::FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* sv/rbft_back.sv */
`default_nettype none
module rbft_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [rbft_pkg::COUNT_W-1:0]  eff_total,
   input  wire logic                          fifo_empty,
   input  wire rbft_pkg::item_type            pop_item,
   output logic                               pop,
   output logic                               rsp_valid,
   output logic [rbft_pkg::OFFSET_W-1:0]      rsp_ack_value,
   output logic [rbft_pkg::SLOT_W-1:0]        rsp_slot_index,
   output logic                               rsp_newly_received,
   output logic                               rsp_out_of_range,
   output logic [rbft_pkg::COUNT_W-1:0]       rsp_inorder_count,
   output logic                               rsp_transfer_complete
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MARK  = 2'd1;
   localparam logic [1:0] S_SREAD = 2'd2;
   localparam logic [1:0] S_SCAN  = 2'd3;

   logic [1:0]                        state_ff, state_in;

   // Current item
   logic [rbft_pkg::OFFSET_W-1:0]     ack_ff;
   logic [rbft_pkg::SLOT_W-1:0]       quot_ff;
   logic                              over_ff, oor_ff, fresh_ff, fresh_in;
   logic [rbft_pkg::COUNT_W-1:0]      front_ff, front_in;

   // Bitmap: rows of words, each row cleared until first written
   logic [rbft_pkg::WORD_W-1:0]       map_mem [rbft_pkg::ROWS];
   logic [rbft_pkg::ROWS-1:0]         row_valid_ff;
   logic [rbft_pkg::WORD_W-1:0]       rd_word_ff;
   logic                              rd_row_valid_ff;
   logic [rbft_pkg::ROW_W-1:0]        rd_row;
   logic                              wr_en;
   logic [rbft_pkg::WORD_W-1:0]       word;

   // Front scan
   logic [rbft_pkg::WORD_W:0]         ext_word, inv_word, low_zero;
   logic [rbft_pkg::SCAN_W-1:0]       ones_run;
   logic [rbft_pkg::COUNT_W-1:0]      cand;
   logic                              ran_off, scan_done;

   // Response registers
   logic                              rsp_valid_ff;
   logic [rbft_pkg::OFFSET_W-1:0]     rsp_ack_ff;
   logic [rbft_pkg::SLOT_W-1:0]       rsp_slot_ff;
   logic                              rsp_new_ff, rsp_oor_ff, rsp_done_ff;
   logic [rbft_pkg::COUNT_W-1:0]      rsp_count_ff;

   assign pop  = (state_ff == S_IDLE) & ~fifo_empty;
   assign word = rd_row_valid_ff ? rd_word_ff : '0;

   // Count the received run starting at the front's bit position
   always_comb begin
      ext_word = {1'b0, word} >> front_ff[rbft_pkg::BIT_W-1:0];
      inv_word = ~ext_word;
      low_zero = inv_word & (~inv_word + 1'b1);
      ones_run = '0;
      for (int i = 0; i <= rbft_pkg::WORD_W; i++) begin
         if (low_zero[i]) begin
            ones_run = ones_run | rbft_pkg::SCAN_W'(i);
         end
      end
   end

   assign cand    = front_ff + rbft_pkg::COUNT_W'(ones_run);
   assign ran_off = (ones_run != '0) && (cand[rbft_pkg::BIT_W-1:0] == '0);

   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      fresh_in  = fresh_ff;
      rd_row    = front_ff[rbft_pkg::SLOT_W-1:rbft_pkg::BIT_W];
      wr_en     = 1'b0;
      scan_done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            rd_row = pop_item.quot[rbft_pkg::SLOT_W-1:rbft_pkg::BIT_W];
            if (pop) begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            fresh_in = ~oor_ff & ~word[quot_ff[rbft_pkg::BIT_W-1:0]];
            wr_en    = fresh_in;
            state_in = S_SREAD;
         end
         S_SREAD: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            rd_row = front_ff[rbft_pkg::SLOT_W-1:rbft_pkg::BIT_W] + 1'b1;
            if (front_ff >= eff_total) begin
               scan_done = 1'b1;
            end else if (cand >= eff_total) begin
               front_in  = eff_total;
               scan_done = 1'b1;
            end else begin
               front_in  = cand;
               scan_done = ~ran_off;
            end
            if (scan_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rsp_valid_ff <= scan_done;
         if (wr_en) begin
            row_valid_ff[quot_ff[rbft_pkg::SLOT_W-1:rbft_pkg::BIT_W]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[quot_ff[rbft_pkg::SLOT_W-1:rbft_pkg::BIT_W]] <=
            word | (rbft_pkg::WORD_W'(1) << quot_ff[rbft_pkg::BIT_W-1:0]);
      end
      rd_word_ff      <= map_mem[rd_row];
      rd_row_valid_ff <= row_valid_ff[rd_row];
   end

   always_ff @(posedge clock) begin
      fresh_ff <= fresh_in;
      if (pop) begin
         ack_ff  <= pop_item.ack;
         quot_ff <= pop_item.quot;
         over_ff <= pop_item.over;
         oor_ff  <= pop_item.over | ({1'b0, pop_item.quot} >= eff_total);
      end
      if (scan_done) begin
         rsp_ack_ff   <= ack_ff;
         rsp_slot_ff  <= over_ff ? rbft_pkg::SLOT_W'(rbft_pkg::MAX_SLOTS - 1) : quot_ff;
         rsp_new_ff   <= fresh_ff;
         rsp_oor_ff   <= oor_ff;
         rsp_count_ff <= front_in;
         rsp_done_ff  <= front_in >= eff_total;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_ack_value         = rsp_ack_ff;
   assign rsp_slot_index        = rsp_slot_ff;
   assign rsp_newly_received    = rsp_new_ff;
   assign rsp_out_of_range      = rsp_oor_ff;
   assign rsp_inorder_count     = rsp_count_ff;
   assign rsp_transfer_complete = rsp_done_ff;

endmodule
`default_nettype wire

/* sv/reorder_bitmap_front_tracker_unit.sv */
// Channel     | Handshake                 | Payload
// ------------+---------------------------+-----------------------------------------
// request     | start / busy              | req_byte_offset, req_payload_size
// response    | rsp_valid (one-cycle)     | rsp_ack_value, rsp_slot_index,
//             |                           | rsp_newly_received, rsp_out_of_range,
//             |                           | rsp_inorder_count, rsp_transfer_complete
// csr         | csr_valid / csr_ready     | csr_data (total segment count)
//
// A request passes the front stage register, the queue and then the back part's bitmap
// walk (read, mark, re-read, scan), which repeats the scan once per extra bitmap word the
// front passes over; the back part takes no new transaction until its walk is done.
// The front part takes a transaction every cycle until the four-entry queue
// fills, then raises busy. Synchronous reset clears the front, the queue and the
// bitmap row-valid bits and sets the total to 1024. Responses cannot be stalled.
`default_nettype none
module reorder_bitmap_front_tracker_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [rbft_pkg::OFFSET_W-1:0]  req_byte_offset,
   input  wire logic [rbft_pkg::SIZE_W-1:0]    req_payload_size,
   output logic                                rsp_valid,
   output logic [rbft_pkg::OFFSET_W-1:0]       rsp_ack_value,
   output logic [rbft_pkg::SLOT_W-1:0]         rsp_slot_index,
   output logic                                rsp_newly_received,
   output logic                                rsp_out_of_range,
   output logic [rbft_pkg::COUNT_W-1:0]        rsp_inorder_count,
   output logic                                rsp_transfer_complete,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rbft_pkg::TOTAL_W-1:0]   csr_data
);

   logic [rbft_pkg::TOTAL_W-1:0]  total_ff;
   logic [rbft_pkg::COUNT_W-1:0]  eff_total;

   logic                          push, fifo_full, fifo_empty, pop;
   rbft_pkg::item_type            push_item, pop_item;

   // The CSR write is always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= rbft_pkg::TOTAL_W'(rbft_pkg::MAX_SLOTS);
      end else if (csr_valid & csr_ready) begin
         total_ff <= csr_data;
      end
   end

   // Clamp the programmed total to the bitmap size
   assign eff_total = (rbft_pkg::COUNT_W'(total_ff) > rbft_pkg::COUNT_W'(rbft_pkg::MAX_SLOTS))
                    ? rbft_pkg::COUNT_W'(rbft_pkg::MAX_SLOTS)
                    : rbft_pkg::COUNT_W'(total_ff);

   // Front: accept, compute ack and slot quotient, classify offsets past the end
   rbft_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .byte_offset  (req_byte_offset),
      .payload_size (req_payload_size),
      .push         (push),
      .push_item    (push_item),
      .fifo_full    (fifo_full)
   );

   // Queue: decouple the arrival pace from the bitmap walk
   rbft_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (fifo_empty)
   );

   // Back: mark the slot, advance the in-order front, drive the response
   rbft_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .eff_total             (eff_total),
      .fifo_empty            (fifo_empty),
      .pop_item              (pop_item),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ack_value         (rsp_ack_value),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_newly_received    (rsp_newly_received),
      .rsp_out_of_range      (rsp_out_of_range),
      .rsp_inorder_count     (rsp_inorder_count),
      .rsp_transfer_complete (rsp_transfer_complete)
   );

endmodule
`default_nettype wire

/* sv/rbft_checker.sv */
`default_nettype none
module rbft_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           busy,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_newly_received,
   input  wire logic                           rsp_out_of_range,
   input  wire logic [rbft_pkg::COUNT_W-1:0]   rsp_inorder_count,
   input  wire logic                           rsp_transfer_complete
);

   // The back part takes no new transaction until its walk is done
   a_no_back_to_back_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses in consecutive cycles");

   // An out-of-range segment never marks the bitmap
   a_oor_not_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> !rsp_newly_received)
      else $error("out-of-range segment reported as new");

   // The front cannot pass the bitmap size; an incomplete transfer is below it
   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_transfer_complete) |->
         (rsp_inorder_count < rbft_pkg::COUNT_W'(rbft_pkg::MAX_SLOTS)))
      else $error("in-order front out of bounds");

   // Reset empties the front stage, so the block takes a request right away
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !busy)
      else $error("busy right after reset");

endmodule

bind reorder_bitmap_front_tracker_unit rbft_checker u_rbft_checker (
   .clock                 (clock),
   .reset                 (reset),
   .busy                  (busy),
   .rsp_valid             (rsp_valid),
   .rsp_newly_received    (rsp_newly_received),
   .rsp_out_of_range      (rsp_out_of_range),
   .rsp_inorder_count     (rsp_inorder_count),
   .rsp_transfer_complete (rsp_transfer_complete)
);
`default_nettype wire
